// File: hw/rtl/greedy_box_nms_defines.svh
// Assertion macros for the greedy box suppression block.
// Used by the port checker; depends on nothing else.
`ifndef GREEDY_BOX_NMS_DEFINES_SVH
`define GREEDY_BOX_NMS_DEFINES_SVH

// condition in the same cycle
`define GBN_ASSERT_NOW(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// condition in the next cycle
`define GBN_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/gbn_pkg.sv
// Shared constants, types and helpers of the greedy box suppression block.
// No dependencies; every other file but the defines header uses it.
package gbn_pkg;

   localparam int MAX_BOXES  = 64;
   localparam int COORD_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int SCORE_W    = 24;
   localparam int THR_W      = 16;
   localparam int LIMIT_W    = 7;
   localparam int THR_FRAC   = 16;
   localparam int IDX_W      = $clog2(MAX_BOXES);
   localparam int CNT_W      = $clog2(MAX_BOXES + 1);
   localparam int LIM_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int AD_W       = COORD_BITS + 2;
   localparam int AREA_W     = 2 * COORD_BITS + 2;
   localparam int TA_W       = 2 * COORD_BITS + THR_FRAC + 3;
   localparam int INTER_W    = 2 * COORD_BITS + 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADD_SCORE = 2'd2;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd32768;
   localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic                         valid;
      logic                         supp;
      logic                         kept;
      logic signed [SCORE_W-1:0]    score;
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] bottom;
      logic signed [TA_W-1:0]       thr_area;
   } cell_type;

   typedef struct packed {
      logic insert;
      logic rotate;
      logic clear;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FLUSH,
      ST_SUPP,
      ST_ALIGN,
      ST_EMIT
   } state_type;

   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b
   );
      logic signed [SCORE_W:0] sum;
      sum = (SCORE_W + 1)'(a) + (SCORE_W + 1)'(b);
      if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         return sum[SCORE_W] ? {1'b1, {(SCORE_W - 1){1'b0}}} : {1'b0, {(SCORE_W - 1){1'b1}}};
      end
      return sum[SCORE_W-1:0];
   endfunction

endpackage

// File: hw/rtl/gbn_if.sv
// Request and response channel interfaces of the greedy box suppression block.
// Depends on gbn_pkg.
interface gbn_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gbn_pkg::FIELD_W-1:0]  score;
   logic signed [gbn_pkg::FIELD_W-1:0]  left;
   logic signed [gbn_pkg::FIELD_W-1:0]  top;
   logic signed [gbn_pkg::FIELD_W-1:0]  right;
   logic signed [gbn_pkg::FIELD_W-1:0]  bottom;
   logic                                final_box;
   modport source(output valid, score, left, top, right, bottom, final_box, input ready);
   modport sink(input valid, score, left, top, right, bottom, final_box, output ready);
endinterface

interface gbn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gbn_pkg::SCORE_W-1:0]  out_score;
   logic signed [gbn_pkg::FIELD_W-1:0]  out_left;
   logic signed [gbn_pkg::FIELD_W-1:0]  out_top;
   logic signed [gbn_pkg::FIELD_W-1:0]  out_right;
   logic signed [gbn_pkg::FIELD_W-1:0]  out_bottom;
   logic                                kept;
   logic                                final_result;
   modport source(output valid, out_score, out_left, out_top, out_right, out_bottom, kept,
                  final_result, input ready);
   modport sink(input valid, out_score, out_left, out_top, out_right, out_bottom, kept,
                final_result, output ready);
endinterface

// File: hw/rtl/greedy_box_nms.sv
// Greedy box suppression. Boxes load one request per cycle into a ring of
// MAX_BOXES cells kept sorted by descending score (ties in arrival order);
// a box arriving when the ring is full is dropped. After the final box the
// ring rotates past one overlap test unit: a box that is kept is tested
// against every unsuppressed box ranked below it and a skipped box is passed
// over; then the ring is realigned and one result per loaded box follows at
// one per cycle while the output is not stalled. No request is taken until
// its results are out.
// Depends on gbn_pkg, gbn_if, gbn_cell and gbn_overlap.
module greedy_box_nms (
   input  logic                           clock,
   input  logic                           reset,
   gbn_req_if.sink                        req_bus,
   gbn_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [gbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbn_pkg::THR_W-1:0]      csr_wdata
);
   import gbn_pkg::*;

   state_type state_ff, state_in;

   logic [THR_W-1:0]   thr_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               add_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] kcnt_ff, kcnt_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] piv_ff, piv_in;
   logic             started_ff, started_in;
   cell_type         pivot_ff, pivot_in;

   logic                         stage_valid_ff, stage_valid_in;
   logic signed [SCORE_W-1:0]    stage_score_ff;
   logic signed [COORD_BITS-1:0] stage_l_ff, stage_t_ff, stage_r_ff, stage_b_ff;
   logic signed [AREA_W-1:0]     stage_area_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   cell_type              rsp_data_ff;
   logic                  rsp_final_ff;

   cell_type     cells [MAX_BOXES];
   logic         keeps [MAX_BOXES];
   cell_type     new_cell, tail, head;
   cell_ctl_type ctl;

   logic req_take, emit_go, at_piv, last_piv, last_pos, below_limit, keep_it, hit;
   logic signed [COORD_BITS-1:0] in_l, in_t, in_r, in_b;
   logic signed [AD_W-1:0]       dx, dy;
   logic signed [2*AD_W-1:0]     area_full;

   assign head = cells[0];

   genvar k;
   generate
      for (k = 0; k < MAX_BOXES; k++) begin : g_cell
         gbn_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .new_data  (new_cell),
            .prev_data ((k == 0) ? new_cell : cells[(k == 0) ? 0 : k - 1]),
            .next_data ((k == MAX_BOXES - 1) ? tail : cells[(k == MAX_BOXES - 1) ? k : k + 1]),
            .prev_keep ((k == 0) ? 1'b1 : keeps[(k == 0) ? 0 : k - 1]),
            .data      (cells[k]),
            .keep      (keeps[k])
         );
      end
   endgenerate

   gbn_overlap u_overlap (
      .pivot (pivot_ff),
      .head  (head),
      .hit   (hit)
   );

   // load path
   always_comb begin
      in_l = req_bus.left[COORD_BITS-1:0];
      in_t = req_bus.top[COORD_BITS-1:0];
      in_r = req_bus.right[COORD_BITS-1:0];
      in_b = req_bus.bottom[COORD_BITS-1:0];
      dx = AD_W'(in_r) - AD_W'(in_l) + AD_W'(1);
      dy = AD_W'(in_b) - AD_W'(in_t) + AD_W'(1);
      area_full = dx * dy;
      new_cell.valid = 1'b1;
      new_cell.supp = 1'b0;
      new_cell.kept = 1'b0;
      new_cell.score = stage_score_ff;
      new_cell.left = stage_l_ff;
      new_cell.top = stage_t_ff;
      new_cell.right = stage_r_ff;
      new_cell.bottom = stage_b_ff;
      new_cell.thr_area = $signed({1'b0, thr_ff}) * stage_area_ff;
   end

   // control outputs
   always_comb begin
      emit_go = !rsp_valid_ff || rsp_bus.ready;
      last_pos = (CNT_W'(pos_ff) + CNT_W'(1)) == cnt_ff;
      req_take = 1'b0;
      ctl = '0;
      case (state_ff)
         ST_LOAD: begin
            req_take = req_bus.valid;
            ctl.insert = stage_valid_ff;
         end
         ST_FLUSH: ctl.insert = stage_valid_ff;
         ST_SUPP:  ctl.rotate = 1'b1;
         ST_ALIGN: ctl.rotate = (pos_ff != '0);
         ST_EMIT: begin
            ctl.rotate = emit_go;
            ctl.clear = emit_go && last_pos;
         end
         default: ctl = '0;
      endcase
   end

   assign req_bus.ready = (state_ff == ST_LOAD);

   // suppression datapath
   always_comb begin
      at_piv = (pos_ff == piv_ff);
      last_piv = (CNT_W'(piv_ff) + CNT_W'(1)) == cnt_ff;
      below_limit = LIM_W'(kcnt_ff) < LIM_W'(limit_ff);
      keep_it = head.valid && !head.supp && below_limit;
      tail = head;
      pivot_in = pivot_ff;
      kcnt_in = kcnt_ff;
      piv_in = piv_ff;
      started_in = started_ff;
      if (state_ff == ST_FLUSH) begin
         kcnt_in = '0;
         piv_in = '0;
         started_in = 1'b0;
      end else if (state_ff == ST_SUPP) begin
         if (!started_ff) begin
            if (keep_it) begin
               tail.kept = 1'b1;
               pivot_in = head;
               kcnt_in = kcnt_ff + CNT_W'(1);
               started_in = 1'b1;
            end else begin
               piv_in = piv_ff + IDX_W'(1);
            end
         end else if (at_piv) begin
            tail.score = pivot_ff.score;
            started_in = 1'b0;
            piv_in = piv_ff + IDX_W'(1);
         end else if (pos_ff > piv_ff && head.valid && !head.supp && hit) begin
            tail.supp = 1'b1;
            if (add_ff) begin
               pivot_in.score = sat_add(pivot_ff.score, head.score);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (req_bus.valid && req_bus.final_box) state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_SUPP;
         ST_SUPP: begin
            if (!started_ff) begin
               if (!keep_it && last_piv) state_in = ST_ALIGN;
            end else if (at_piv) begin
               if (last_piv || !below_limit) state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: if (pos_ff == '0) state_in = ST_EMIT;
         ST_EMIT:  if (emit_go && last_pos) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // counters and response register
   always_comb begin
      cnt_in = cnt_ff;
      stage_valid_in = 1'b0;
      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (req_take && (cnt_ff < CNT_W'(MAX_BOXES))) begin
         stage_valid_in = 1'b1;
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (ctl.rotate) begin
         pos_in = (pos_ff == IDX_W'(MAX_BOXES - 1)) ? '0 : pos_ff + IDX_W'(1);
      end
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_valid_in = 1'b1;
      end
      if (ctl.clear) begin
         cnt_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         thr_ff <= THRESHOLD_RESET;
         limit_ff <= KEEP_LIMIT_RESET;
         add_ff <= 1'b0;
         cnt_ff <= '0;
         kcnt_ff <= '0;
         pos_ff <= '0;
         piv_ff <= '0;
         started_ff <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         kcnt_ff <= kcnt_in;
         pos_ff <= pos_in;
         piv_ff <= piv_in;
         started_ff <= started_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD:  thr_ff <= csr_wdata;
               CSR_KEEP_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
               CSR_ADD_SCORE:  add_ff <= csr_wdata[0];
               default:        add_ff <= add_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pivot_ff <= pivot_in;
      if (req_take) begin
         stage_score_ff <= SCORE_W'(req_bus.score);
         stage_l_ff <= in_l;
         stage_t_ff <= in_t;
         stage_r_ff <= in_r;
         stage_b_ff <= in_b;
         stage_area_ff <= AREA_W'(area_full);
      end
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_data_ff <= head;
         rsp_final_ff <= last_pos;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_score = rsp_data_ff.score;
   assign rsp_bus.out_left = FIELD_W'(rsp_data_ff.left);
   assign rsp_bus.out_top = FIELD_W'(rsp_data_ff.top);
   assign rsp_bus.out_right = FIELD_W'(rsp_data_ff.right);
   assign rsp_bus.out_bottom = FIELD_W'(rsp_data_ff.bottom);
   assign rsp_bus.kept = rsp_data_ff.kept;
   assign rsp_bus.final_result = rsp_final_ff;

endmodule

// File: hw/rtl/gbn_cell.sv
// One entry of the box ring: sorted insertion on load, rotation during
// suppression, realignment and output, then clear. Depends on gbn_pkg.
module gbn_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gbn_pkg::cell_ctl_type ctl,
   input  gbn_pkg::cell_type     new_data,
   input  gbn_pkg::cell_type     prev_data,
   input  gbn_pkg::cell_type     next_data,
   input  logic                  prev_keep,
   output gbn_pkg::cell_type     data,
   output logic                  keep
);
   import gbn_pkg::*;

   cell_type data_ff, data_in;

   assign keep = data_ff.valid && (data_ff.score >= new_data.score);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.clear) begin
         data_in.valid = 1'b0;
         data_in.supp = 1'b0;
         data_in.kept = 1'b0;
      end else if (ctl.rotate) begin
         data_in = next_data;
      end else if (ctl.insert) begin
         if (!prev_keep) begin
            data_in = prev_data;
         end else if (!keep) begin
            data_in = new_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
         data_ff.supp <= 1'b0;
         data_ff.kept <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

endmodule

// File: hw/rtl/gbn_overlap.sv
// Overlap test of the ring head against the current kept box:
// intersection scaled by 65536 against threshold times area. Depends on gbn_pkg.
module gbn_overlap (
   input  gbn_pkg::cell_type pivot,
   input  gbn_pkg::cell_type head,
   output logic              hit
);
   import gbn_pkg::*;

   logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
   logic signed [AD_W-1:0]       w, h;
   logic [COORD_BITS:0]          wu, hu;
   logic [INTER_W-1:0]           inter;
   logic signed [TA_W-1:0]       lhs;
   logic                         w_pos, h_pos;

   always_comb begin
      x1 = (pivot.left > head.left) ? pivot.left : head.left;
      y1 = (pivot.top > head.top) ? pivot.top : head.top;
      x2 = (pivot.right < head.right) ? pivot.right : head.right;
      y2 = (pivot.bottom < head.bottom) ? pivot.bottom : head.bottom;
      w = AD_W'(x2) - AD_W'(x1) + AD_W'(1);
      h = AD_W'(y2) - AD_W'(y1) + AD_W'(1);
      w_pos = !w[AD_W-1] && (w != '0);
      h_pos = !h[AD_W-1] && (h != '0);
      wu = w[COORD_BITS:0];
      hu = h[COORD_BITS:0];
      inter = INTER_W'(wu) * INTER_W'(hu);
      lhs = $signed({1'b0, inter, {THR_FRAC{1'b0}}});
      hit = w_pos && h_pos && (lhs > head.thr_area);
   end

endmodule

// File: hw/rtl/gbn_checker.sv
// Port-level checks of the greedy box suppression block, bound to its top.
// Depends on gbn_pkg and greedy_box_nms_defines.svh.
`include "greedy_box_nms_defines.svh"

module gbn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_final_box,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [gbn_pkg::SCORE_W-1:0] rsp_out_score,
   input logic                          rsp_kept,
   input logic                          rsp_final_result
);
   import gbn_pkg::*;

   `GBN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_score) && $stable(rsp_kept) && $stable(rsp_final_result))
   `GBN_ASSERT_NEXT(a_final_blocks, clock, reset, req_valid && req_ready && req_final_box, !req_ready)
   `GBN_ASSERT_NOW(a_emit_blocks, clock, reset, $rose(rsp_valid) && !rsp_final_result, !req_ready)
   `GBN_ASSERT_NEXT(a_set_ends, clock, reset, rsp_valid && rsp_ready && rsp_final_result, !rsp_valid)

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_final_box    (req_bus.final_box),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_out_score    (rsp_bus.out_score),
   .rsp_kept         (rsp_bus.kept),
   .rsp_final_result (rsp_bus.final_result)
);
